FILE: sv/bitmap_shape_drawing_engine_macros.svh
// Assertion macros shared by the drawing engine modules.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef BITMAP_SHAPE_DRAWING_ENGINE_MACROS_SVH
`define BITMAP_SHAPE_DRAWING_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BSDE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define BSDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define BSDE_ASSERT_IMPL(lbl, ante, cons)
`define BSDE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/bsde_pkg.sv
package bsde_pkg;

  localparam int ACT_W     = 3;
  localparam int POS_W     = 5;
  localparam int EXT_W     = 6;
  localparam int CNT_W     = 6;
  localparam int ROW_SUM_W = 7;

  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_OUTLINE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FILL    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_HLINE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_VLINE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ    = 3'd5;

  typedef struct packed {
    logic load;
    logic issue;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } dp_status_t;

endpackage

FILE: sv/bitmap_shape_drawing_engine.sv
// Channel   Handshake            Signals
// command   start & !busy        action start_row start_col box_height box_width line_length
// result    done (one cycle)     pixel_value done_action
//
// A command reads one row each cycle in the sweep, n being the screen rows it touches (1 to
// 32); a command that touches none still passes through sweep and flush. The last row write
// lands during flush, then done is high for one cycle. Rows are read-modify-written through
// one row-wide memory, read and write of adjacent rows overlapping. Clear touches no rows and
// drops per-row valid bits; read touches at most one row and writes none. Reset is synchronous
// and empties the screen at once. The receiver cannot stall; busy drops in the done cycle.
module bitmap_shape_drawing_engine #(
  parameter int SCREEN_DIM = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [bsde_pkg::ACT_W-1:0] action,
  input  logic [bsde_pkg::POS_W-1:0] start_row,
  input  logic [bsde_pkg::POS_W-1:0] start_col,
  input  logic [bsde_pkg::EXT_W-1:0] box_height,
  input  logic [bsde_pkg::EXT_W-1:0] box_width,
  input  logic [bsde_pkg::EXT_W-1:0] line_length,
  output logic                       done,
  output logic                       pixel_value,
  output logic [bsde_pkg::ACT_W-1:0] done_action
);
  import bsde_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bsde_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  bsde_datapath #(
    .SCREEN_DIM (SCREEN_DIM)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .action      (action),
    .start_row   (start_row),
    .start_col   (start_col),
    .box_height  (box_height),
    .box_width   (box_width),
    .line_length (line_length),
    .pixel_value (pixel_value),
    .done_action (done_action)
  );

endmodule

FILE: sv/bsde_datapath.sv
module bsde_datapath #(
  parameter int SCREEN_DIM = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bsde_pkg::ctrl_cmd_t      cmd,
  output bsde_pkg::dp_status_t     status,
  input  logic [bsde_pkg::ACT_W-1:0] action,
  input  logic [bsde_pkg::POS_W-1:0] start_row,
  input  logic [bsde_pkg::POS_W-1:0] start_col,
  input  logic [bsde_pkg::EXT_W-1:0] box_height,
  input  logic [bsde_pkg::EXT_W-1:0] box_width,
  input  logic [bsde_pkg::EXT_W-1:0] line_length,
  output logic                     pixel_value,
  output logic [bsde_pkg::ACT_W-1:0] done_action
);
  import bsde_pkg::*;

  localparam int RW = $clog2(SCREEN_DIM);
  localparam logic [ROW_SUM_W-1:0] DIM = ROW_SUM_W'(SCREEN_DIM);

  function automatic logic [SCREEN_DIM-1:0] span(input logic [ROW_SUM_W-1:0] lo,
                                                input logic [ROW_SUM_W-1:0] cnt);
    logic [SCREEN_DIM-1:0] m;
    logic [ROW_SUM_W-1:0]  hi;
    hi = lo + cnt;
    for (int j = 0; j < SCREEN_DIM; j++) begin
      m[j] = (ROW_SUM_W'(j) >= lo) && (ROW_SUM_W'(j) < hi);
    end
    return m;
  endfunction

  logic [SCREEN_DIM-1:0] mem [SCREEN_DIM];
  logic [SCREEN_DIM-1:0] row_valid;

  logic [ACT_W-1:0]      act;
  logic [POS_W-1:0]      r0;
  logic [POS_W-1:0]      c0;
  logic [EXT_W-1:0]      bh;
  logic [EXT_W-1:0]      bw;
  logic [EXT_W-1:0]      ln;
  logic [CNT_W-1:0]      n;
  logic [CNT_W-1:0]      i;
  logic [SCREEN_DIM-1:0] rd_data;
  logic                  rd_valid;
  logic                  wr_pending;
  logic [RW-1:0]         wr_addr;
  logic                  wr_edge;
  logic                  pixel;

  // Row count of the incoming command, clipped at the bottom of the screen
  logic [EXT_W-1:0]     ext_in;
  logic [ROW_SUM_W-1:0] room;
  logic                 row_on;
  logic [CNT_W-1:0]     n_in;

  always_comb begin
    unique case (action)
      ACT_OUTLINE, ACT_FILL: ext_in = (box_width == '0) ? '0 : box_height;
      ACT_HLINE:             ext_in = (line_length == '0) ? '0 : EXT_W'(1);
      ACT_VLINE:             ext_in = line_length;
      ACT_READ:  ext_in = ({2'b00, start_col} < DIM) ? EXT_W'(1) : '0;
      default:               ext_in = '0;
    endcase
    room   = DIM - {2'b00, start_row};
    row_on = {2'b00, start_row} < DIM;
    if (!row_on) begin
      n_in = '0;
    end else if ({1'b0, ext_in} < room) begin
      n_in = CNT_W'(ext_in);
    end else begin
      n_in = CNT_W'(room);
    end
  end

  logic [ROW_SUM_W-1:0]  cur_row;
  logic [RW-1:0]         rd_addr;
  logic [ROW_SUM_W-1:0]  c0w;
  logic [ROW_SUM_W-1:0]  bw7;
  logic [ROW_SUM_W-1:0]  wsel;
  logic [SCREEN_DIM-1:0] run_mask;
  logic [SCREEN_DIM-1:0] end_mask;
  logic [SCREEN_DIM-1:0] old_row;
  logic [SCREEN_DIM-1:0] new_row;
  logic [SCREEN_DIM-1:0] sh;

  always_comb begin
    cur_row = {2'b00, r0} + {1'b0, i};
    rd_addr = cur_row[RW-1:0];
    c0w     = {2'b00, c0};
    bw7     = {1'b0, bw};
    unique case (act)
      ACT_HLINE: wsel = {1'b0, ln};
      ACT_VLINE: wsel = ROW_SUM_W'(1);
      default:   wsel = bw7;
    endcase
    run_mask = span(c0w, wsel);
    end_mask = span(c0w, ROW_SUM_W'(1)) | span(c0w + bw7 - ROW_SUM_W'(1), ROW_SUM_W'(1));
    old_row  = rd_valid ? rd_data : '0;
    // Outline interior rows keep only the two side pixels inside the span
    if (act == ACT_OUTLINE && !wr_edge) begin
      new_row = (old_row & ~run_mask) | end_mask;
    end else begin
      new_row = old_row | run_mask;
    end
    sh = rd_data >> c0;
  end

  assign status.empty = (n == '0);
  assign status.last  = ((i + CNT_W'(1)) == n);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      r0  <= start_row;
      c0  <= start_col;
      bh  <= box_height;
      bw  <= box_width;
      ln  <= line_length;
      n   <= n_in;
      i   <= '0;
    end else if (cmd.issue) begin
      i <= i + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= row_valid[rd_addr];
      wr_addr  <= rd_addr;
      wr_edge  <= (i == '0) || (i == (bh - EXT_W'(1)));
    end
    if (wr_pending) begin
      mem[wr_addr] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      wr_pending <= 1'b0;
    end else begin
      wr_pending <= cmd.issue && (act != ACT_READ);
      if (cmd.load && action == ACT_CLEAR) begin
        row_valid <= '0;
      end else if (wr_pending) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      pixel <= (act == ACT_READ) && (n != '0) && rd_valid && sh[0];
    end
  end

  assign pixel_value = pixel;
  assign done_action = act;

endmodule

FILE: sv/bsde_ctrl.sv
`include "bitmap_shape_drawing_engine_macros.svh"

module bsde_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output bsde_pkg::ctrl_cmd_t  cmd,
  input  bsde_pkg::dp_status_t status
);
  import bsde_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SWEEP,
    FLUSH
  } state_t;

  state_t state;

  assign busy      = (state != IDLE);
  assign cmd.load  = (state == IDLE) && start;
  assign cmd.issue = (state == SWEEP) && !status.empty;
  assign cmd.flush = (state == FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= SWEEP;
          end
        end
        SWEEP: begin
          // When rows remain, the last row read goes out now; its write lands during flush
          if (status.empty || status.last) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          done  <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `BSDE_ASSERT_NEXT(a_flush_gives_done, cmd.flush, done)
  `BSDE_ASSERT_IMPL(a_done_when_idle, done, !busy)
  `BSDE_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy && !done)
  `BSDE_ASSERT_IMPL(a_issue_has_rows, cmd.issue, !status.empty && busy)

endmodule
